### design/usd_pkg.sv
// Shared types and byte-class constants for the UTF-8 stream decoder.
// No dependencies.
package usd_pkg;

   localparam int CP_WIDTH = 21;
   localparam int COUNT_WIDTH = 3;

   localparam logic [7:0] CONT_MASK  = 8'hC0;
   localparam logic [7:0] CONT_CODE  = 8'h80;
   localparam logic [7:0] LEAD2_MASK = 8'hE0;
   localparam logic [7:0] LEAD2_CODE = 8'hC0;
   localparam logic [7:0] LEAD3_MASK = 8'hF0;
   localparam logic [7:0] LEAD3_CODE = 8'hE0;
   localparam logic [7:0] LEAD4_MASK = 8'hF8;
   localparam logic [7:0] LEAD4_CODE = 8'hF0;
   localparam logic [7:0] VAL2_MASK  = 8'h1F;
   localparam logic [7:0] VAL3_MASK  = 8'h0F;
   localparam logic [7:0] VAL4_MASK  = 8'h07;
   localparam logic [7:0] VALC_MASK  = 8'h3F;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_payload_type;

   typedef struct packed {
      logic [CP_WIDTH-1:0] code_point;
      logic                bad_byte;
      logic                run_last;
   } rsp_payload_type;

   // All beats of a burst but the last are error marks.
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [CP_WIDTH-1:0]    last_cp;
      logic                   last_bad;
   } usd_burst_type;

endpackage

### design/usd_decode.sv
// Sequence state and per-byte decode into a burst descriptor.
// Depends on usd_pkg.
module usd_decode
   import usd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            take,
   input  req_payload_type req_payload,
   output usd_burst_type   burst,
   output logic            seq_open
);

   logic [2:0]          exp_len_ff, exp_len_in;
   logic [2:0]          collected_ff, collected_in;
   logic [CP_WIDTH-1:0] partial_ff, partial_in;

   logic [7:0]          b;
   logic                eot;
   logic                lead_count, lead_bad, lead_open;
   logic [CP_WIDTH-1:0] lead_cp, lead_val, cont_val;
   logic [2:0]          lead_len, next_collected;

   assign b = req_payload.data_byte;
   assign eot = req_payload.end_of_text;
   assign seq_open = (exp_len_ff != 3'd0);

   always_comb begin
      lead_count = 1'b0;
      lead_bad = 1'b0;
      lead_open = 1'b0;
      lead_cp = '0;
      lead_val = '0;
      lead_len = 3'd0;
      if (b[7] == 1'b0) begin
         lead_count = 1'b1;
         lead_cp = {{(CP_WIDTH-8){1'b0}}, b};
      end else if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         lead_len = 3'd2;
         lead_val = {{(CP_WIDTH-8){1'b0}}, b & VAL2_MASK};
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         lead_len = 3'd3;
         lead_val = {{(CP_WIDTH-8){1'b0}}, b & VAL3_MASK};
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         lead_len = 3'd4;
         lead_val = {{(CP_WIDTH-8){1'b0}}, b & VAL4_MASK};
      end else begin
         lead_count = 1'b1;
         lead_bad = 1'b1;
      end
      if (lead_len != 3'd0) begin
         if (eot) begin
            lead_count = 1'b1;
            lead_bad = 1'b1;
         end else begin
            lead_open = 1'b1;
         end
      end
   end

   assign cont_val = {partial_ff[CP_WIDTH-7:0], b[5:0] & VALC_MASK[5:0]};
   assign next_collected = collected_ff + 3'd1;

   always_comb begin
      burst = '0;
      exp_len_in = exp_len_ff;
      collected_in = collected_ff;
      partial_in = partial_ff;
      if (exp_len_ff != 3'd0 && (b & CONT_MASK) == CONT_CODE) begin
         if (next_collected >= exp_len_ff) begin
            burst.count = 3'd1;
            burst.last_cp = cont_val;
            exp_len_in = 3'd0;
            collected_in = 3'd0;
            partial_in = '0;
         end else if (eot) begin
            burst.count = next_collected;
            burst.last_bad = 1'b1;
            exp_len_in = 3'd0;
            collected_in = 3'd0;
            partial_in = '0;
         end else begin
            collected_in = next_collected;
            partial_in = cont_val;
         end
      end else begin
         burst.count = collected_ff + {2'b00, lead_count};
         burst.last_bad = lead_count ? lead_bad : 1'b1;
         burst.last_cp = (lead_count && !lead_bad) ? lead_cp : '0;
         exp_len_in = lead_open ? lead_len : 3'd0;
         collected_in = lead_open ? 3'd1 : 3'd0;
         partial_in = lead_open ? lead_val : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_len_ff <= 3'd0;
         collected_ff <= 3'd0;
         partial_ff <= '0;
      end else if (take) begin
         exp_len_ff <= exp_len_in;
         collected_ff <= collected_in;
         partial_ff <= partial_in;
      end
   end

endmodule

### design/usd_emit.sv
// Result register: holds one burst and plays it out one beat per cycle while rsp_ready is high.
// Depends on usd_pkg.
module usd_emit
   import usd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            load,
   input  usd_burst_type   burst,
   output logic            free,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [CP_WIDTH-1:0]    last_cp_ff;
   logic                   last_bad_ff;
   logic                   last_beat;

   assign last_beat = (count_ff == 3'd1);
   assign rsp_valid = (count_ff != 3'd0);
   assign free = !rsp_valid || (last_beat && rsp_ready);

   always_comb begin
      rsp_payload.code_point = last_beat ? last_cp_ff : '0;
      rsp_payload.bad_byte = last_beat ? last_bad_ff : 1'b1;
      rsp_payload.run_last = last_beat;
   end

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = burst.count;
      end else if (rsp_valid && rsp_ready) begin
         count_in = count_ff - 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 3'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         last_cp_ff <= burst.last_cp;
         last_bad_ff <= burst.last_bad;
      end
   end

endmodule

### design/utf8_stream_decoder_top.sv
// UTF-8 stream decoder top level: decode stage feeding the result register.
// Depends on usd_pkg, usd_decode and usd_emit.
// The first result beat of a byte is valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte gives at most one beat and rsp_ready is high;
// a byte that gives n beats holds the input until its last beat is taken (free from the result register).
// Reset clears the open sequence and empties the result register.
module utf8_stream_decoder_top
   import usd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   usd_burst_type burst;
   logic          take;
   logic          free;
   logic          seq_open;

   assign req_ready = free;
   assign take = req_valid && req_ready;

   usd_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .take        (take),
      .req_payload (req_payload),
      .burst       (burst),
      .seq_open    (seq_open)
   );

   usd_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .load        (take),
      .burst       (burst),
      .free        (free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   a_ready_only_when_drained: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || (rsp_ready && rsp_payload.run_last)))
      else $error("input taken while burst still pending");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_payload.run_last) |=> rsp_valid)
      else $error("burst ended without a final beat");

   a_closed_after_end: assert property (@(posedge clock) disable iff (reset)
      (take && req_payload.end_of_text) |=> !seq_open)
      else $error("sequence left open after end of text");

   a_error_zero_cp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.bad_byte) |-> (rsp_payload.code_point == '0))
      else $error("error beat carries a code point");

endmodule

### test/utf8_stream_decoder_top_tb.sv
// Self-checking testbench for utf8_stream_decoder_top: directed byte table, then random text.
// Checks every result beat against an in-bench decoder model and the typed table entries.
// Depends on usd_pkg and utf8_stream_decoder_top.
module utf8_stream_decoder_top_tb;
   import usd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;
   localparam int DIRECTED_ROWS = 26;
   localparam int RANDOM_PER_PHASE = 75;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic [7:0]          data_byte;
      logic                end_of_text;
      logic                typed;
      logic [CP_WIDTH-1:0] code_point;
      logic                bad_byte;
   } text_row_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   req_payload_type req_payload = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   rsp_payload_type rsp_payload;

   text_row_type    text_rows [DIRECTED_ROWS];
   rsp_payload_type pending_points [$];
   rsp_payload_type decoded_beats [4];
   int              decoded_count;

   logic [COUNT_WIDTH-1:0] seq_len = '0;
   logic [COUNT_WIDTH-1:0] seq_taken = '0;
   logic [CP_WIDTH-1:0]    seq_value = '0;

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int mismatch_count = 0;
   int cycle_count = 0;

   utf8_stream_decoder_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   task push_decoded(input logic [CP_WIDTH-1:0] cp, input logic bad);
      decoded_beats[decoded_count].code_point = bad ? '0 : cp;
      decoded_beats[decoded_count].bad_byte = bad;
      decoded_beats[decoded_count].run_last = 1'b0;
      decoded_count++;
   endtask

   task close_sequence;
      seq_len = '0;
      seq_taken = '0;
      seq_value = '0;
   endtask

   task open_lead(input logic [7:0] b, input logic eot);
      logic [COUNT_WIDTH-1:0] len;
      logic [7:0]             bits;
      if ((b & CONT_CODE) == 8'h00) begin
         push_decoded({13'h0, b}, 1'b0);
         return;
      end
      if ((b & LEAD2_MASK) == LEAD2_CODE) begin
         len = 3'd2;
         bits = b & VAL2_MASK;
      end else if ((b & LEAD3_MASK) == LEAD3_CODE) begin
         len = 3'd3;
         bits = b & VAL3_MASK;
      end else if ((b & LEAD4_MASK) == LEAD4_CODE) begin
         len = 3'd4;
         bits = b & VAL4_MASK;
      end else begin
         push_decoded('0, 1'b1);
         return;
      end
      if (eot) begin
         push_decoded('0, 1'b1);
         return;
      end
      seq_len = len;
      seq_taken = 3'd1;
      seq_value = {13'h0, bits};
   endtask

   task decode_byte(input logic [7:0] b, input logic eot);
      logic [7:0] cont_bits;
      decoded_count = 0;
      if (seq_len != '0) begin
         if ((b & CONT_MASK) == CONT_CODE) begin
            cont_bits = b & VALC_MASK;
            seq_value = {seq_value[CP_WIDTH-7:0], cont_bits[5:0]};
            seq_taken = seq_taken + 3'd1;
            if (seq_taken >= seq_len) begin
               push_decoded(seq_value, 1'b0);
               close_sequence();
            end else if (eot) begin
               for (int i = 0; i < seq_taken && decoded_count < 4; i++)
                  push_decoded('0, 1'b1);
               close_sequence();
            end
         end else begin
            for (int i = 0; i < seq_taken && decoded_count < 3; i++)
               push_decoded('0, 1'b1);
            close_sequence();
            open_lead(b, eot);
         end
      end else begin
         open_lead(b, eot);
      end
      if (decoded_count > 0)
         decoded_beats[decoded_count-1].run_last = 1'b1;
   endtask

   task expect_beat(input rsp_payload_type beat);
      pending_points.insert(pending_points.size(), beat);
   endtask

   // Call at a rising edge; returns at the edge that accepts the beat.
   task send_beat(input logic [7:0] b, input logic eot, input logic typed,
                  input logic [CP_WIDTH-1:0] typed_cp, input logic typed_bad);
      rsp_payload_type typed_beat;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload.data_byte <= b;
      req_payload.end_of_text <= eot;
      do
         @(negedge clock);
      while (!req_ready);
      @(posedge clock);
      decode_byte(b, eot);
      if (typed) begin
         typed_beat.code_point = typed_cp;
         typed_beat.bad_byte = typed_bad;
         typed_beat.run_last = 1'b1;
         expect_beat(typed_beat);
      end else begin
         for (int i = 0; i < decoded_count; i++)
            expect_beat(decoded_beats[i]);
      end
   endtask

   task send_random_text(input int n_bytes);
      int         sent;
      int         pick;
      int         len;
      int         taken;
      logic [7:0] rb;
      logic [7:0] lead;
      logic       eot;
      sent = 0;
      while (sent < n_bytes) begin
         pick = $urandom_range(0, 99);
         rb = 8'($urandom);
         if (pick < 85) begin
            len = (pick < 70) ? $urandom_range(1, 4) : $urandom_range(2, 4);
            case (len)
               1: lead = {1'b0, rb[6:0]};
               2: lead = {3'b110, rb[4:0]};
               3: lead = {4'b1110, rb[3:0]};
               default: lead = {5'b11110, rb[2:0]};
            endcase
            // cut the sequence short when pick >= 70; end of text may mark its last byte either way
            taken = (pick < 70) ? len : $urandom_range(1, len - 1);
            for (int i = 0; i < taken; i++) begin
               rb = 8'($urandom);
               eot = (i == taken - 1) && ($urandom_range(0, 99) < ((pick < 70) ? 20 : 50));
               send_beat((i == 0) ? lead : {2'b10, rb[5:0]}, eot, 1'b0, '0, 1'b0);
               sent++;
            end
            if (pick >= 70 && !eot) begin
               rb = 8'($urandom);
               if ((rb & CONT_MASK) == CONT_CODE)
                  rb = rb ^ 8'h40;
               send_beat(rb, $urandom_range(0, 3) == 0, 1'b0, '0, 1'b0);
               sent++;
            end
         end else begin
            send_beat(rb, $urandom_range(0, 3) == 0, 1'b0, '0, 1'b0);
            sent++;
         end
      end
   endtask

   always @(negedge clock) begin : check_beat
      rsp_payload_type golden;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_points.size() == 0) begin
            $error("unexpected beat: code_point %h bad_byte %b run_last %b",
                   rsp_payload.code_point, rsp_payload.bad_byte, rsp_payload.run_last);
            mismatch_count++;
         end else begin
            golden = pending_points.pop_front();
            if (rsp_payload.code_point !== golden.code_point) begin
               $error("code_point: expected %h, got %h",
                      golden.code_point, rsp_payload.code_point);
               mismatch_count++;
            end
            if (rsp_payload.bad_byte !== golden.bad_byte) begin
               $error("bad_byte: expected %b, got %b", golden.bad_byte, rsp_payload.bad_byte);
               mismatch_count++;
            end
            if (rsp_payload.run_last !== golden.run_last) begin
               $error("run_last: expected %b, got %b", golden.run_last, rsp_payload.run_last);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      text_rows[0]  = {8'h00, 1'b0, 1'b1, 21'h000000, 1'b0};
      text_rows[1]  = {8'h7F, 1'b1, 1'b1, 21'h00007F, 1'b0};
      text_rows[2]  = {8'h80, 1'b0, 1'b1, 21'h000000, 1'b1};
      text_rows[3]  = {8'hBF, 1'b1, 1'b1, 21'h000000, 1'b1};
      text_rows[4]  = {8'hF8, 1'b0, 1'b1, 21'h000000, 1'b1};
      text_rows[5]  = {8'hFF, 1'b0, 1'b1, 21'h000000, 1'b1};
      text_rows[6]  = {8'hC2, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[7]  = {8'hA9, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[8]  = {8'hE2, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[9]  = {8'h82, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[10] = {8'hAC, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[11] = {8'hF7, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[12] = {8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[13] = {8'hBF, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[14] = {8'hBF, 1'b1, 1'b0, 21'h000000, 1'b0};
      text_rows[15] = {8'hC0, 1'b1, 1'b1, 21'h000000, 1'b1};
      text_rows[16] = {8'hF4, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[17] = {8'h8F, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[18] = {8'h8F, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[19] = {8'h41, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[20] = {8'hE1, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[21] = {8'h80, 1'b1, 1'b0, 21'h000000, 1'b0};
      text_rows[22] = {8'hC3, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[23] = {8'hE0, 1'b1, 1'b0, 21'h000000, 1'b0};
      text_rows[24] = {8'hDF, 1'b0, 1'b0, 21'h000000, 1'b0};
      text_rows[25] = {8'hFF, 1'b1, 1'b0, 21'h000000, 1'b0};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_beat(text_rows[i].data_byte, text_rows[i].end_of_text, text_rows[i].typed,
                   text_rows[i].code_point, text_rows[i].bad_byte);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
            default: begin send_idle_pct = 15; recv_stall_pct = 15; end
         endcase
         send_random_text(RANDOM_PER_PHASE);
      end
      req_valid <= 1'b0;

      while (pending_points.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

### sim.f
design/usd_pkg.sv
design/usd_decode.sv
design/usd_emit.sv
design/utf8_stream_decoder_top.sv
test/utf8_stream_decoder_top_tb.sv
